// ===== hw/rtl/lstk_pkg.sv =====
// Shared types and constants for the bounded stack.
`default_nettype none

package lstk_pkg;

    localparam int DEFAULT_DEPTH     = 256;
    localparam int DEFAULT_WORD_BITS = 32;

    localparam int DATA_BITS = 32;
    localparam int POS_BITS  = 9;
    localparam int CAP_BITS  = 9;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        FN_PUSH = 2'd0,
        FN_POP  = 2'd1,
        FN_PEEK = 2'd2,
        FN_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_POS   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the accepted operation
        logic exec;     // update count, write or read the entry store
        logic load;     // move the finished result into the output register
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lstk_ctrl.sv =====
// Controller: sequences capture, execute and result load, and owns the handshakes.
`default_nettype none

module lstk_ctrl
    import lstk_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                // hold here while the previous result still waits
                if (out_free) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lstk_dp.sv =====
// Datapath: entry store, entry count, capacity register and result register.
`default_nettype none

module lstk_dp
    import lstk_pkg::*;
#(
    parameter int DEPTH     = DEFAULT_DEPTH,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    input  wire logic                  cfg_valid,
    input  wire logic [CAP_BITS-1:0]   cfg_data,
    input  wire logic [1:0]            s_func,
    input  wire logic [DATA_BITS-1:0]  s_push_value,
    input  wire logic [POS_BITS-1:0]   s_position,
    output logic [DATA_BITS-1:0]       m_read_value,
    output logic [1:0]                 m_status,
    output logic                       m_is_full,
    output logic                       m_is_empty
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] mem_q;

    func_t                func_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CAP_BITS-1:0]  cap_reg;
    status_t              status_reg, status_next;
    logic                 hit_reg, hit_next;

    logic [DATA_BITS-1:0] read_value_reg;
    status_t              status_out_reg;
    logic                 full_out_reg;
    logic                 empty_out_reg;

    logic [WORD_BITS-1:0] word_in;
    logic [DATA_BITS-1:0] mem_word;
    logic [CMPW-1:0]      cnt_ext, pos_ext, cap_ext, eff_cap, peek_diff;
    logic [CW-1:0]        cnt_m1;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic                 full_now;

    generate
        if (WORD_BITS >= DATA_BITS) begin : g_wide
            assign word_in  = WORD_BITS'(s_push_value);
            assign mem_word = mem_q[DATA_BITS-1:0];
        end else begin : g_narrow
            assign word_in  = s_push_value[WORD_BITS-1:0];
            assign mem_word = DATA_BITS'(mem_q);
        end
    endgenerate

    assign cnt_ext   = CMPW'(count_reg);
    assign pos_ext   = CMPW'(pos_reg);
    assign cap_ext   = CMPW'(cap_reg);
    assign cnt_m1    = count_reg - 1'b1;
    assign peek_diff = cnt_ext - pos_ext;

    // Zero capacity acts as one, anything past the store acts as its depth.
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_ext > CMPW'(DEPTH)) begin
            eff_cap = CMPW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign full_now = (cnt_ext >= eff_cap);

    always_comb begin
        count_next  = count_reg;
        status_next = ST_OK;
        hit_next    = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = cnt_m1[AW-1:0];
        unique case (func_reg)
            FN_PUSH: begin
                if (full_now) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_POP: begin
                if (count_reg == '0) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    hit_next   = 1'b1;
                    count_next = cnt_m1;
                end
            end
            FN_PEEK: begin
                if (pos_reg == '0 || pos_ext > cnt_ext) begin
                    status_next = ST_BAD_POS;
                end else begin
                    hit_next = 1'b1;
                    rd_addr  = peek_diff[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (wr_en) begin
                mem[count_reg[AW-1:0]] <= word_reg;
            end
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (cmd.exec) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= func_t'(s_func);
            word_reg <= word_in;
            pos_reg  <= s_position;
        end
        if (cmd.exec) begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
        // count already reflects this item when the result is loaded
        if (cmd.load) begin
            read_value_reg <= hit_reg ? mem_word : '1;
            status_out_reg <= status_reg;
            full_out_reg   <= full_now;
            empty_out_reg  <= (count_reg == '0);
        end
    end

    assign m_read_value = read_value_reg;
    assign m_status     = status_out_reg;
    assign m_is_full    = full_out_reg;
    assign m_is_empty   = empty_out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_stack_with_peek.sv =====
// Top level of the bounded stack with peek.
`default_nettype none

// Bounded LIFO stack of signed words: push, pop, or peek at a depth counted from the top
// (1 is the top). Each operation runs from transfer in to result ready through capture,
// one entry store access with a registered read, and the load of the result register.
// The result register lets the next operation enter while a result still waits, and a
// waiting result stalls only the final load step. The entry store needs no clearing
// after reset. Write capacity only while the stack is idle.
module bounded_stack_with_peek
    import lstk_pkg::*;
#(
    parameter int DEPTH     = DEFAULT_DEPTH,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CAP_BITS-1:0]         cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_func,
    input  wire logic signed [DATA_BITS-1:0] s_push_value,
    input  wire logic [POS_BITS-1:0]         s_position,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [DATA_BITS-1:0]      m_read_value,
    output logic [1:0]                       m_status,
    output logic                             m_is_full,
    output logic                             m_is_empty
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    lstk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lstk_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .s_func       (s_func),
        .s_push_value (s_push_value),
        .s_position   (s_position),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_is_full    (m_is_full),
        .m_is_empty   (m_is_empty)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lstk_checker.sv =====
// Port-level checker for the bounded stack, bound to the top level.
`default_nettype none

module lstk_checker
    import lstk_pkg::*;
(
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic [CAP_BITS-1:0]         cfg_data,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic [1:0]                  s_func,
    input wire logic signed [DATA_BITS-1:0] s_push_value,
    input wire logic [POS_BITS-1:0]         s_position,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic signed [DATA_BITS-1:0] m_read_value,
    input wire logic [1:0]                  m_status,
    input wire logic                        m_is_full,
    input wire logic                        m_is_empty
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value) && $stable(m_status))
        else $error("result changed while stalled");

    // Capacity is at least one, so full and empty never coincide.
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_full && m_is_empty))
        else $error("full and empty together");

    // Any error returns all ones.
    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_read_value == '1))
        else $error("error without all-ones value");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OVERFLOW) |-> m_is_full)
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_UNDERFLOW) |-> m_is_empty)
        else $error("underflow reported while not empty");

endmodule

bind bounded_stack_with_peek lstk_checker u_lstk_checker (.*);

`default_nettype wire

// ===== sim/bounded_stack_with_peek_tb.sv =====
// Self-checking testbench for the bounded stack with peek.
`timescale 1ns / 100ps

module bounded_stack_with_peek_tb;
    import lstk_pkg::*;

    localparam int          STACK_DEPTH = DEFAULT_DEPTH;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam int          TIMEOUT_NS  = 5_000_000;

    typedef enum logic { ROW_OP, ROW_CFG } row_kind_t;
    typedef enum int { PH_PLAIN, PH_FILL, PH_DRAIN } phase_kind_t;

    typedef struct packed {
        logic [31:0] read_value;
        status_t     status;
        logic        is_full;
        logic        is_empty;
    } stack_result_t;

    // For configuration rows the value column holds the capacity.
    typedef struct packed {
        row_kind_t     kind;
        func_t         func;
        logic [31:0]   value;
        logic [8:0]    position;
        logic          typed;
        stack_result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 29;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_OP,  FN_POP,  32'h0000_0000, 9'd0,   1'b1, '{ALL_ONES, ST_UNDERFLOW, 1'b0, 1'b1}},
        '{ROW_OP,  FN_PEEK, 32'h0000_0000, 9'd0,   1'b1, '{ALL_ONES, ST_BAD_POS,   1'b0, 1'b1}},
        '{ROW_OP,  FN_PEEK, 32'h0000_0000, 9'd1,   1'b1, '{ALL_ONES, ST_BAD_POS,   1'b0, 1'b1}},
        '{ROW_OP,  FN_NONE, 32'h1234_5678, 9'd511, 1'b1, '{ALL_ONES, ST_OK,        1'b0, 1'b1}},
        '{ROW_OP,  FN_PUSH, 32'h7FFF_FFFF, 9'd0,   1'b1, '{ALL_ONES, ST_OK,        1'b0, 1'b0}},
        '{ROW_OP,  FN_PUSH, 32'h8000_0000, 9'd511, 1'b1, '{ALL_ONES, ST_OK,        1'b0, 1'b0}},
        '{ROW_OP,  FN_PEEK, 32'h0000_0000, 9'd1,   1'b1, '{32'h8000_0000, ST_OK,   1'b0, 1'b0}},
        '{ROW_OP,  FN_PEEK, 32'hFFFF_FFFF, 9'd2,   1'b1, '{32'h7FFF_FFFF, ST_OK,   1'b0, 1'b0}},
        '{ROW_OP,  FN_PEEK, 32'h0000_0000, 9'd3,   1'b1, '{ALL_ONES, ST_BAD_POS,   1'b0, 1'b0}},
        '{ROW_OP,  FN_PEEK, 32'h0000_0000, 9'd511, 1'b1, '{ALL_ONES, ST_BAD_POS,   1'b0, 1'b0}},
        '{ROW_CFG, FN_NONE, 32'd2,         9'd0,   1'b0, '0},
        '{ROW_OP,  FN_PUSH, 32'hFFFF_FFFF, 9'd0,   1'b1, '{ALL_ONES, ST_OVERFLOW,  1'b1, 1'b0}},
        '{ROW_OP,  FN_PEEK, 32'h0000_0000, 9'd0,   1'b1, '{ALL_ONES, ST_BAD_POS,   1'b1, 1'b0}},
        '{ROW_OP,  FN_POP,  32'h0000_0000, 9'd0,   1'b1, '{32'h8000_0000, ST_OK,   1'b0, 1'b0}},
        '{ROW_OP,  FN_POP,  32'h0000_0000, 9'd0,   1'b1, '{32'h7FFF_FFFF, ST_OK,   1'b0, 1'b1}},
        '{ROW_CFG, FN_NONE, 32'd0,         9'd0,   1'b0, '0},
        '{ROW_OP,  FN_PUSH, 32'h0000_0000, 9'd0,   1'b1, '{ALL_ONES, ST_OK,        1'b1, 1'b0}},
        '{ROW_OP,  FN_PUSH, 32'h0000_0001, 9'd0,   1'b1, '{ALL_ONES, ST_OVERFLOW,  1'b1, 1'b0}},
        '{ROW_OP,  FN_NONE, 32'h0000_0000, 9'd0,   1'b1, '{ALL_ONES, ST_OK,        1'b1, 1'b0}},
        '{ROW_OP,  FN_POP,  32'h0000_0000, 9'd0,   1'b1, '{32'h0000_0000, ST_OK,   1'b0, 1'b1}},
        '{ROW_CFG, FN_NONE, 32'd511,       9'd0,   1'b0, '0},
        '{ROW_OP,  FN_PUSH, 32'h5A5A_5A5A, 9'd0,   1'b0, '0},
        '{ROW_OP,  FN_PUSH, 32'hA5A5_A5A5, 9'd0,   1'b0, '0},
        '{ROW_OP,  FN_PEEK, 32'h0000_0000, 9'd256, 1'b0, '0},
        '{ROW_CFG, FN_NONE, 32'd1,         9'd0,   1'b0, '0},
        '{ROW_OP,  FN_PUSH, 32'h0000_0001, 9'd0,   1'b1, '{ALL_ONES, ST_OVERFLOW,  1'b1, 1'b0}},
        '{ROW_OP,  FN_PEEK, 32'h0000_0000, 9'd2,   1'b1, '{32'h5A5A_5A5A, ST_OK,   1'b1, 1'b0}},
        '{ROW_OP,  FN_POP,  32'h0000_0000, 9'd0,   1'b1, '{32'hA5A5_A5A5, ST_OK,   1'b1, 1'b0}},
        '{ROW_OP,  FN_POP,  32'h0000_0000, 9'd0,   1'b1, '{32'h5A5A_5A5A, ST_OK,   1'b0, 1'b1}}
    };

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CAP_BITS-1:0]    cfg_data     = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_func       = FN_NONE;
    logic [DATA_BITS-1:0]   s_push_value = '0;
    logic [POS_BITS-1:0]    s_position   = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [DATA_BITS-1:0]   m_read_value;
    logic [1:0]             m_status;
    logic                   m_is_full;
    logic                   m_is_empty;

    // Typed expectation carried along with the payload of a directed row.
    logic                   row_typed    = 1'b0;
    stack_result_t          row_want     = '0;

    // Predictor state, updated on each transfer.
    logic [31:0]            stack_mem [STACK_DEPTH];
    int                     stack_depth  = 0;
    logic [8:0]             stack_cap    = CAP_RESET;
    stack_result_t          pending [$];

    // Sender-side view of the stack, used only to shape stimulus.
    int                     issued_depth = 0;
    logic [8:0]             tx_cap       = CAP_RESET;
    bit                     tx_quiet     = 1'b0;
    bit                     rx_quiet     = 1'b0;
    int                     err_count    = 0;

    bounded_stack_with_peek dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_push_value (s_push_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_is_full    (m_is_full),
        .m_is_empty   (m_is_empty)
    );

    always #10 aclk = ~aclk;

    function automatic int cap_in_use(logic [8:0] c);
        if (c == 9'd0) return 1;
        if (int'(c) > STACK_DEPTH) return STACK_DEPTH;
        return int'(c);
    endfunction

    function automatic stack_result_t stack_apply(func_t f, logic [31:0] v, logic [8:0] p);
        stack_result_t r;
        int            cap;
        cap          = cap_in_use(stack_cap);
        r.read_value = ALL_ONES;
        r.status     = ST_OK;
        case (f)
            FN_PUSH: begin
                if (stack_depth >= cap) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    stack_mem[stack_depth] = v;
                    stack_depth++;
                end
            end
            FN_POP: begin
                if (stack_depth == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    stack_depth--;
                    r.read_value = stack_mem[stack_depth];
                end
            end
            FN_PEEK: begin
                if (p == 9'd0 || int'(p) > stack_depth) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.read_value = stack_mem[stack_depth - int'(p)];
                end
            end
            default: ;
        endcase
        r.is_full  = (stack_depth >= cap);
        r.is_empty = (stack_depth == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t ns: %s got %h expected %h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin : scoreboard
        stack_result_t want;
        if (!aresetn) begin
            stack_depth = 0;
            stack_cap   = CAP_RESET;
            pending.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending.size() == 0) begin
                    report_mismatch("unexpected result, read_value", m_read_value, '0);
                end else begin
                    want = pending.pop_front();
                    if (m_read_value !== want.read_value)
                        report_mismatch("read_value", m_read_value, want.read_value);
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_is_full !== want.is_full)
                        report_mismatch("is_full", 32'(m_is_full), 32'(want.is_full));
                    if (m_is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(m_is_empty), 32'(want.is_empty));
                end
            end
            if (cfg_valid && cfg_ready)
                stack_cap = cfg_data;
            if (s_valid && s_ready) begin
                want = stack_apply(func_t'(s_func), s_push_value, s_position);
                if (row_typed)
                    want = row_want;
                pending.push_back(want);
            end
        end
    end

    // Result side: draw a stall before each transfer.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // Hold until every accepted item has produced its result.
    task automatic wait_idle();
        @(negedge aclk);
        while (pending.size() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_capacity(logic [8:0] c);
        s_valid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tx_cap = c;
    endtask

    task automatic issue_op(func_t f, logic [31:0] v, logic [8:0] p, logic typed,
                            stack_result_t want);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_push_value <= v;
        s_position   <= p;
        row_typed    <= typed;
        row_want     <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (f == FN_PUSH && issued_depth < cap_in_use(tx_cap))
            issued_depth++;
        else if (f == FN_POP && issued_depth > 0)
            issued_depth--;
    endtask

    function automatic logic [31:0] draw_word();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return ALL_ONES;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Fill phases mostly push until full, drain phases mostly pop until empty; both then
    // run n_items balanced transfers, which plain phases run from the start.
    task automatic run_phase(logic [8:0] c, phase_kind_t kind, int n_items, bit tq, bit rq);
        int          tail;
        int          r;
        int          push_pct;
        int          pop_pct;
        bit          reached;
        func_t       f;
        logic [8:0]  p;
        write_capacity(c);
        tx_quiet = tq;
        rx_quiet = rq;
        tail     = 0;
        reached  = (kind == PH_PLAIN);
        while (tail < n_items) begin
            if (!reached && kind == PH_FILL) begin
                push_pct = 97;
                pop_pct  = 1;
            end else if (!reached) begin
                push_pct = 2;
                pop_pct  = 90;
            end else begin
                push_pct = 35;
                pop_pct  = 30;
            end
            r = $urandom_range(0, 99);
            if (r < push_pct)
                f = FN_PUSH;
            else if (r < push_pct + pop_pct)
                f = FN_POP;
            else if ($urandom_range(0, 9) == 0)
                f = FN_NONE;
            else
                f = FN_PEEK;
            if (issued_depth > 0 && $urandom_range(0, 4) != 0)
                p = 9'($urandom_range(1, issued_depth));
            else
                p = 9'($urandom_range(0, 511));
            issue_op(f, draw_word(), p, 1'b0, '0);
            if (reached)
                tail++;
            else if (kind == PH_FILL)
                reached = (issued_depth >= cap_in_use(tx_cap));
            else
                reached = (issued_depth == 0);
        end
    endtask

    initial begin : stimulus
        dir_row_t row;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TABLE[i];
            if (row.kind == ROW_CFG)
                write_capacity(row.value[8:0]);
            else
                issue_op(row.func, row.value, row.position, row.typed, row.want);
        end

        run_phase(9'd100, PH_FILL, 40, 1'b0, 1'b0);
        // Capacity drops far below the count here.
        run_phase(9'd1, PH_PLAIN, 30, 1'b1, 1'b1);
        run_phase(9'd257, PH_DRAIN, 10, 1'b0, 1'b0);
        run_phase(9'd0, PH_PLAIN, 20, 1'b0, 1'b1);
        run_phase(9'd3, PH_PLAIN, 25, 1'b1, 1'b0);
        run_phase(9'($urandom_range(1, 16)), PH_PLAIN, 30, 1'b0, 1'b0);
        run_phase(9'($urandom_range(0, 511)), PH_PLAIN, 30, 1'b0, 1'b0);

        s_valid <= 1'b0;
        wait_idle();
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("TIMEOUT at %0t ns", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lstk_pkg.sv
hw/rtl/lstk_ctrl.sv
hw/rtl/lstk_dp.sv
hw/rtl/bounded_stack_with_peek.sv
hw/rtl/lstk_checker.sv
sim/bounded_stack_with_peek_tb.sv
